@@ design/sat_pkg.sv @@
package sat_pkg;

  localparam int SEGMENT_SLOTS_DEF = 8;
  localparam int MEMORY_BYTES_DEF = 65536;

  // Request command codes. Code 3 has no meaning and leaves all state alone.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_XLATE = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_TABLE_FULL = 3'd1;
  localparam logic [2:0] STAT_BAD_PARAMS = 3'd2;
  localparam logic [2:0] STAT_NO_SEGMENT = 3'd3;
  localparam logic [2:0] STAT_OVER_LIMIT = 3'd4;
  localparam logic [2:0] STAT_PROTECTION = 3'd5;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  segment_number;
    logic [15:0] base_address;
    logic [16:0] segment_limit;
    logic [16:0] offset;
    logic [2:0]  rights_mask;
  } sat_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] physical_address;
    logic [2:0]  assigned_slot;
    logic [31:0] access_total;
    logic [31:0] segment_fault_total;
    logic [31:0] protection_error_total;
  } sat_rsp_t;

  typedef struct packed {
    logic load;
    logic commit;
  } sat_ctrl_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

@@ design/sat_if.sv @@
interface sat_req_if;
  logic               valid;
  logic               ready;
  sat_pkg::sat_req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sat_rsp_if;
  logic               valid;
  logic               ready;
  sat_pkg::sat_rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/sat_ctrl.sv @@
module sat_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sat_pkg::sat_ctrl_t ctrl
);
  import sat_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign ctrl.load   = in_fire;
  // The held request executes once the output register is free or being drained.
  assign ctrl.commit = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ctrl.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("accepted request did not move the controller to execute");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> out_valid_r)
    else $error("executed request did not produce a valid result");

  a_stall_holds_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && !out_ready) |=> state_r == ST_EXEC)
    else $error("request left execute while the result was stalled");

endmodule

@@ design/sat_dpath.sv @@
module sat_dpath #(
  parameter int SEGMENT_SLOTS = sat_pkg::SEGMENT_SLOTS_DEF,
  parameter int MEMORY_BYTES  = sat_pkg::MEMORY_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sat_pkg::sat_ctrl_t ctrl,
  input  sat_pkg::sat_req_t  req_data,
  output sat_pkg::sat_rsp_t  rsp_data
);
  import sat_pkg::*;

  localparam int IDX_W = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
  localparam int CNT_W = $clog2(SEGMENT_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SEGMENT_SLOTS);
  localparam logic [17:0] MEM_LIM = 18'(MEMORY_BYTES);

  sat_req_t    req_r;
  sat_rsp_t    rsp_r, rsp_nxt;
  logic [15:0] seg_base_r   [SEGMENT_SLOTS];
  logic [16:0] seg_limit_r  [SEGMENT_SLOTS];
  logic [2:0]  seg_rights_r [SEGMENT_SLOTS];
  logic [CNT_W-1:0] seg_count_r, seg_count_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] fault_r, fault_nxt;
  logic [31:0] prot_r, prot_nxt;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [4:0]       cnt_ext;
  logic             seg_missing;
  logic             tbl_we;
  logic [15:0]      sel_base;
  logic [16:0]      sel_limit;
  logic [2:0]       sel_rights;
  logic [17:0]      add_end;
  logic             add_bad;
  logic [16:0]      phys_sum;

  // Slots fill in order and clear all at once, so a slot is live exactly
  // when its number is below the fill count.
  assign cnt_ext     = 5'(seg_count_r);
  assign seg_missing = ({1'b0, req_r.segment_number} >= cnt_ext);
  assign rd_idx      = req_r.segment_number[IDX_W-1:0];
  assign wr_idx      = seg_count_r[IDX_W-1:0];
  assign sel_base    = seg_base_r[rd_idx];
  assign sel_limit   = seg_limit_r[rd_idx];
  assign sel_rights  = seg_rights_r[rd_idx];
  assign add_end     = 18'(req_r.base_address) + 18'(req_r.segment_limit);
  assign add_bad     = (req_r.segment_limit == 17'd0) || (add_end > MEM_LIM);
  assign phys_sum    = {1'b0, sel_base} + req_r.offset;

  always_comb begin
    seg_count_nxt = seg_count_r;
    acc_nxt       = acc_r;
    fault_nxt     = fault_r;
    prot_nxt      = prot_r;
    tbl_we        = 1'b0;
    rsp_nxt       = '0;
    unique case (req_r.command)
      CMD_CLEAR: begin
        seg_count_nxt = '0;
        acc_nxt       = '0;
        fault_nxt     = '0;
        prot_nxt      = '0;
      end
      CMD_ADD: begin
        if (seg_count_r >= SLOTS_C) begin
          rsp_nxt.status = STAT_TABLE_FULL;
        end else if (add_bad) begin
          rsp_nxt.status = STAT_BAD_PARAMS;
        end else begin
          tbl_we                = 1'b1;
          seg_count_nxt         = seg_count_r + 1'b1;
          rsp_nxt.assigned_slot = cnt_ext[2:0];
        end
      end
      CMD_XLATE: begin
        acc_nxt = sat_inc(acc_r);
        if (seg_missing) begin
          rsp_nxt.status = STAT_NO_SEGMENT;
          fault_nxt      = sat_inc(fault_r);
        end else if (req_r.offset > sel_limit) begin
          rsp_nxt.status = STAT_OVER_LIMIT;
          fault_nxt      = sat_inc(fault_r);
        end else if ((sel_rights & req_r.rights_mask) == 3'd0) begin
          rsp_nxt.status = STAT_PROTECTION;
          prot_nxt       = sat_inc(prot_r);
        end else begin
          rsp_nxt.physical_address = phys_sum;
        end
      end
      default: begin
      end
    endcase
    rsp_nxt.access_total           = acc_nxt;
    rsp_nxt.segment_fault_total    = fault_nxt;
    rsp_nxt.protection_error_total = prot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
      acc_r       <= '0;
      fault_r     <= '0;
      prot_r      <= '0;
    end else if (ctrl.commit) begin
      seg_count_r <= seg_count_nxt;
      acc_r       <= acc_nxt;
      fault_r     <= fault_nxt;
      prot_r      <= prot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_r <= req_data;
    end
    if (ctrl.commit) begin
      rsp_r <= rsp_nxt;
    end
    if (ctrl.commit && tbl_we) begin
      seg_base_r[wr_idx]   <= req_r.base_address;
      seg_limit_r[wr_idx]  <= req_r.segment_limit;
      seg_rights_r[wr_idx] <= req_r.rights_mask;
    end
  end

  assign rsp_data = rsp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seg_count_r <= SLOTS_C)
    else $error("segment fill count exceeds the table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.commit && req_r.command == CMD_CLEAR)
      |=> (seg_count_r == '0 && acc_r == '0 && fault_r == '0 && prot_r == '0))
    else $error("clear request left table or counters nonzero");

  a_add_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.commit && req_r.command == CMD_ADD && rsp_nxt.status == STAT_OK)
      |=> seg_count_r == CNT_W'($past(seg_count_r) + 1'b1))
    else $error("successful add did not advance the fill count");

endmodule

@@ design/segment_address_translator_core.sv @@
// Segment base/limit address translator.
// Requests arrive on in_req (valid/ready); each carries a command: clear the
// segment table and counters, add a segment (base, limit, rights) in the next
// free slot, or translate a segment number and offset for an access kind.
// Every request gives exactly one result on out_rsp (valid/ready) with a
// status code, the physical address, the assigned slot and the three
// saturating access, fault and protection counters after the update.
// A request accepted into the request register executes in the execute state and
// its result is then registered in the output register.
// A new request is taken only once the last one has executed, set by the
// controller's capture-then-execute sequence: idle takes it, execute runs it.
// The result sits in an output register: a new request is accepted while the
// previous result waits. When the receiver stalls, the captured request waits
// in execute until the output register is drained, and in_req.ready stays low.
// Reset (synchronous, active low) empties the table and zeroes the counters;
// no clearing pass is needed, the block accepts requests right after reset.
module segment_address_translator_core #(
  parameter int SEGMENT_SLOTS = sat_pkg::SEGMENT_SLOTS_DEF,
  parameter int MEMORY_BYTES  = sat_pkg::MEMORY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sat_req_if.sink   in_req,
  sat_rsp_if.source out_rsp
);
  import sat_pkg::*;

  sat_ctrl_t ctrl;
  logic      in_ready;
  logic      out_valid;
  sat_rsp_t  rsp_data;

  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .ctrl      (ctrl)
  );

  sat_dpath #(
    .SEGMENT_SLOTS (SEGMENT_SLOTS),
    .MEMORY_BYTES  (MEMORY_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .req_data (in_req.data),
    .rsp_data (rsp_data)
  );

  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid;
  assign out_rsp.data  = rsp_data;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import sat_pkg::*;

  localparam real CLK_PERIOD  = 8.0;
  localparam int  SLOTS       = SEGMENT_SLOTS_DEF;
  localparam int  MEM_BYTES   = MEMORY_BYTES_DEF;
  localparam int  RANDOM_REQS = 900;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_WAIT  = 10;
  localparam int  REQ_W       = $bits(sat_req_t);

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] RIGHTS_NONE = 3'b000;
  localparam logic [2:0] RIGHTS_READ = 3'b001;
  localparam logic [2:0] RIGHTS_WX   = 3'b110;
  localparam logic [2:0] RIGHTS_ALL  = 3'b111;

  typedef struct {
    sat_req_t req;
    bit       typed;
    sat_rsp_t rsp;
  } plan_row_t;

  localparam sat_rsp_t NO_RSP = '0;

  logic clk;
  logic rst_n;

  sat_req_if req_if ();
  sat_rsp_if rsp_if ();

  segment_address_translator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  // Shadow of the segment table and counters.
  logic [15:0] tbl_base   [SLOTS];
  logic [16:0] tbl_limit  [SLOTS];
  logic [2:0]  tbl_rights [SLOTS];
  bit          tbl_used   [SLOTS];
  int          used_slots;
  logic [31:0] accesses;
  logic [31:0] faults;
  logic [31:0] denials;

  sat_rsp_t  pending_rsp_q[$];
  plan_row_t plan[$];
  int        mismatches;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic sat_req_t mk_req(logic [1:0] cmd, logic [3:0] segn, logic [15:0] base,
                                      logic [16:0] lim, logic [16:0] off, logic [2:0] rights);
    sat_req_t r;
    r.command        = cmd;
    r.segment_number = segn;
    r.base_address   = base;
    r.segment_limit  = lim;
    r.offset         = off;
    r.rights_mask    = rights;
    return r;
  endfunction

  function automatic sat_rsp_t mk_rsp(logic [2:0] status, logic [16:0] phys, logic [2:0] slot,
                                      logic [31:0] acc, logic [31:0] flt, logic [31:0] prot);
    sat_rsp_t r;
    r.status                 = status;
    r.physical_address       = phys;
    r.assigned_slot          = slot;
    r.access_total           = acc;
    r.segment_fault_total    = flt;
    r.protection_error_total = prot;
    return r;
  endfunction

  function automatic logic [31:0] saturating_bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_base[i]   = '0;
      tbl_limit[i]  = '0;
      tbl_rights[i] = '0;
      tbl_used[i]   = 1'b0;
    end
    used_slots = 0;
    accesses   = '0;
    faults     = '0;
    denials    = '0;
  endtask

  // Applies one request to the shadow table and returns the result it gives.
  task automatic translate_predict(input sat_req_t r, output sat_rsp_t rsp);
    int segn;
    rsp  = NO_RSP;
    segn = r.segment_number;
    case (r.command)
      CMD_CLEAR: begin
        wipe_table();
      end
      CMD_ADD: begin
        if (used_slots >= SLOTS) begin
          rsp.status = STAT_TABLE_FULL;
        end else if (r.segment_limit == 0 ||
                     int'(r.base_address) + int'(r.segment_limit) > MEM_BYTES) begin
          rsp.status = STAT_BAD_PARAMS;
        end else begin
          tbl_base[used_slots]   = r.base_address;
          tbl_limit[used_slots]  = r.segment_limit;
          tbl_rights[used_slots] = r.rights_mask;
          tbl_used[used_slots]   = 1'b1;
          rsp.assigned_slot      = used_slots[2:0];
          used_slots++;
        end
      end
      CMD_XLATE: begin
        accesses = saturating_bump(accesses);
        if (segn >= used_slots || segn >= SLOTS || !tbl_used[segn]) begin
          rsp.status = STAT_NO_SEGMENT;
          faults     = saturating_bump(faults);
        end else if (r.offset > tbl_limit[segn]) begin
          rsp.status = STAT_OVER_LIMIT;
          faults     = saturating_bump(faults);
        end else if ((tbl_rights[segn] & r.rights_mask) == 0) begin
          rsp.status = STAT_PROTECTION;
          denials    = saturating_bump(denials);
        end else begin
          rsp.physical_address = 17'(tbl_base[segn] + r.offset);
        end
      end
      default: begin
      end
    endcase
    rsp.access_total           = accesses;
    rsp.segment_fault_total    = faults;
    rsp.protection_error_total = denials;
  endtask

  // Drives one request from the falling edge and waits until it is taken.
  task automatic send_request(input sat_req_t req, input bit typed, input sat_rsp_t typed_rsp);
    sat_rsp_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      req_if.data  <= sat_req_t'($urandom);
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    translate_predict(req, predicted);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
  endtask

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result channel: random back-pressure, checked at each accepting edge.
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sat_rsp_t want;
    sat_rsp_t got;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = rsp_if.data;
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_rsp_q.pop_front();
        field_check("status", 32'(want.status), 32'(got.status));
        field_check("physical_address", 32'(want.physical_address),
                    32'(got.physical_address));
        field_check("assigned_slot", 32'(want.assigned_slot), 32'(got.assigned_slot));
        field_check("access_total", want.access_total, got.access_total);
        field_check("segment_fault_total", want.segment_fault_total,
                    got.segment_fault_total);
        field_check("protection_error_total", want.protection_error_total,
                    got.protection_error_total);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_rsp_q.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    sat_req_t req;
    int       pick;
    int       lim;
    int       seg_lim;
    int       phase_stall [4];
    int       phase_idle  [4];

    phase_idle  = '{0, 56, 0, 22};
    phase_stall = '{0, 0, 56, 22};
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    wipe_table();

    // Directed requests; counters are typed in where they follow at a glance.
    plan.push_back('{mk_req(CMD_XLATE, 0, 0, 0, 0, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_NO_SEGMENT, 0, 0, 1, 1, 0)});
    plan.push_back('{mk_req(CMD_UNUSED, 15, 16'hFFFF, 17'h10000, 17'h1FFFF, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_OK, 0, 0, 1, 1, 0)});
    plan.push_back('{mk_req(CMD_ADD, 0, 0, 0, 0, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_BAD_PARAMS, 0, 0, 1, 1, 0)});
    plan.push_back('{mk_req(CMD_ADD, 0, 0, 17'h10000, 0, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_OK, 0, 0, 1, 1, 0)});
    plan.push_back('{mk_req(CMD_ADD, 0, 1, 17'h10000, 0, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_BAD_PARAMS, 0, 0, 1, 1, 0)});
    plan.push_back('{mk_req(CMD_ADD, 0, 16'hFFFF, 1, 0, RIGHTS_READ), 1'b1,
                     mk_rsp(STAT_OK, 0, 1, 1, 1, 0)});
    // An offset equal to the limit is still inside the segment.
    plan.push_back('{mk_req(CMD_XLATE, 0, 0, 0, 17'h10000, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_OK, 17'h10000, 0, 2, 1, 0)});
    plan.push_back('{mk_req(CMD_XLATE, 0, 0, 0, 17'h1FFFF, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_OVER_LIMIT, 0, 0, 3, 2, 0)});
    plan.push_back('{mk_req(CMD_XLATE, 1, 0, 0, 1, RIGHTS_READ), 1'b1,
                     mk_rsp(STAT_OK, 17'h10000, 0, 4, 2, 0)});
    plan.push_back('{mk_req(CMD_XLATE, 1, 0, 0, 0, RIGHTS_NONE), 1'b1,
                     mk_rsp(STAT_PROTECTION, 0, 0, 5, 2, 1)});
    plan.push_back('{mk_req(CMD_XLATE, 1, 0, 0, 0, RIGHTS_WX), 1'b1,
                     mk_rsp(STAT_PROTECTION, 0, 0, 6, 2, 2)});
    plan.push_back('{mk_req(CMD_XLATE, 15, 0, 0, 0, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_NO_SEGMENT, 0, 0, 7, 3, 2)});
    for (int i = 2; i < SLOTS; i++) begin
      plan.push_back('{mk_req(CMD_ADD, 0, 16'(i * 256), 17'h100, 0, 3'(i)), 1'b0, NO_RSP});
    end
    // A full table wins over a zero limit.
    plan.push_back('{mk_req(CMD_ADD, 0, 0, 0, 0, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_TABLE_FULL, 0, 0, 7, 3, 2)});
    plan.push_back('{mk_req(CMD_XLATE, 7, 0, 0, 17'h100, RIGHTS_ALL), 1'b0, NO_RSP});
    plan.push_back('{mk_req(CMD_XLATE, 8, 0, 0, 0, RIGHTS_ALL), 1'b0, NO_RSP});
    plan.push_back('{mk_req(CMD_CLEAR, 0, 0, 0, 0, RIGHTS_NONE), 1'b1,
                     mk_rsp(STAT_OK, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_req(CMD_XLATE, 0, 0, 0, 0, RIGHTS_ALL), 1'b1,
                     mk_rsp(STAT_NO_SEGMENT, 0, 0, 1, 1, 0)});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      send_request(plan[i].req, plan[i].typed, plan[i].rsp);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int n = 0; n < RANDOM_REQS / 4; n++) begin
        req = REQ_W'({$urandom, $urandom});
        req.segment_limit = 17'($urandom_range(0, 65536));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          req.command = CMD_CLEAR;
        end else if (pick < 5) begin
          req.command = CMD_UNUSED;
        end else if (pick < 27) begin
          req.command = CMD_ADD;
          pick = $urandom_range(0, 9);
          if (pick <= 6) begin
            lim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65536)
                                              : $urandom_range(1, 4096);
            req.segment_limit = 17'(lim);
            req.base_address  = 16'($urandom_range(0, MEM_BYTES - lim));
          end else if (pick == 7) begin
            req.segment_limit = '0;
          end else if (pick == 9) begin
            // Segment that ends exactly at the top of memory.
            req.segment_limit = 17'(MEM_BYTES - int'(req.base_address));
          end
        end else begin
          req.command = CMD_XLATE;
          if ($urandom_range(0, 4) != 0) begin
            req.segment_number = 4'($urandom_range(0, used_slots));
          end
          seg_lim = (req.segment_number < SLOTS) ? int'(tbl_limit[req.segment_number]) : 0;
          pick = $urandom_range(0, 9);
          if (pick <= 4) begin
            req.offset = 17'($urandom_range(0, seg_lim));
          end else if (pick == 5) begin
            req.offset = 17'(seg_lim);
          end else if (pick == 6) begin
            req.offset = 17'(seg_lim + 1);
          end else if (pick == 7) begin
            req.offset = '0;
          end
        end
        send_request(req, 1'b0, NO_RSP);
      end
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
